[sv/nfhf_pkg.sv]
// Shared types, constants and codes for the navigation filter health failsafe.
package nfhf_pkg;

	localparam int unsigned VARIANCE_WIDTH_DEFAULT = 16;
	localparam int unsigned THRESHOLD_WIDTH        = 16;
	localparam int unsigned CFG_DATA_WIDTH         = 32;
	localparam int unsigned CFG_INDEX_WIDTH        = 2;
	localparam int unsigned QUEUE_DEPTH            = 4;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_EKF_THRESHOLD   = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAILSAFE_ACTION = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAIL_LIMIT      = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_WARN_INTERVAL   = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET     = 16'd205;
	localparam logic [1:0]                 ACTION_RESET        = 2'd2;
	localparam logic [7:0]                 FAIL_LIMIT_RESET    = 8'd10;
	localparam logic [31:0]                WARN_INTERVAL_RESET = 32'd30000;

	// Failsafe action codes; every code at or above hold requests hold.
	localparam logic [1:0] ACT_DISABLE = 2'd0;
	localparam logic [1:0] ACT_REPORT  = 2'd1;
	localparam logic [1:0] ACT_HOLD    = 2'd2;

	typedef enum logic [1:0] {
		VEV_NONE    = 2'd0,
		VEV_BAD     = 2'd1,
		VEV_CLEARED = 2'd2
	} var_event_t;

	typedef enum logic [1:0] {
		FEV_NONE     = 2'd0,
		FEV_ENGAGED  = 2'd1,
		FEV_RESOLVED = 2'd2
	} fs_event_t;

	typedef enum logic [1:0] {
		MSG_NONE     = 2'd0,
		MSG_FAILSAFE = 2'd1,
		MSG_CLEARED  = 2'd2
	} fs_msg_t;

	// What the back end has to do with one classified tick.
	typedef enum logic [1:0] {
		CMD_IGNORE = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_GOOD   = 2'd2,
		CMD_BAD    = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        needs_position;
		logic [31:0] now_ms;
	} nfhf_cmd_t;

	typedef struct packed {
		logic [THRESHOLD_WIDTH-1:0] ekf_threshold;
		logic [1:0]                 failsafe_action;
		logic [7:0]                 fail_limit;
		logic [31:0]                warn_interval_ms;
	} nfhf_cfg_t;

endpackage

[sv/nfhf_ifs.sv]
// Channel interfaces for check ticks and for results.
interface nfhf_in_if #(
	parameter int unsigned VarWidth = nfhf_pkg::VARIANCE_WIDTH_DEFAULT
);
	logic                valid;
	logic                ready;
	logic                origin_valid;
	logic                armed;
	logic [VarWidth-1:0] vel_variance;
	logic [VarWidth-1:0] pos_variance;
	logic [VarWidth-1:0] mag_variance_x;
	logic [VarWidth-1:0] mag_variance_y;
	logic [VarWidth-1:0] mag_variance_z;
	logic                flow_healthy;
	logic                inertial_nav_ok;
	logic [4:0]          nav_flags;
	logic                needs_position;
	logic [31:0]         now_ms;

	modport source (
		output valid, origin_valid, armed, vel_variance, pos_variance,
		       mag_variance_x, mag_variance_y, mag_variance_z, flow_healthy,
		       inertial_nav_ok, nav_flags, needs_position, now_ms,
		input  ready
	);
	modport sink (
		input  valid, origin_valid, armed, vel_variance, pos_variance,
		       mag_variance_x, mag_variance_y, mag_variance_z, flow_healthy,
		       inertial_nav_ok, nav_flags, needs_position, now_ms,
		output ready
	);
endinterface

interface nfhf_out_if;
	logic       valid;
	logic       ready;
	logic       variance_bad;
	logic       failsafe_active;
	logic [1:0] variance_event;
	logic [1:0] failsafe_event;
	logic       send_variance_warning;
	logic [1:0] failsafe_message;
	logic       request_hold;

	modport source (
		output valid, variance_bad, failsafe_active, variance_event, failsafe_event,
		       send_variance_warning, failsafe_message, request_hold,
		input  ready
	);
	modport sink (
		input  valid, variance_bad, failsafe_active, variance_event, failsafe_event,
		       send_variance_warning, failsafe_message, request_hold,
		output ready
	);
endinterface

[sv/nfhf_front.sv]
// Front end: accepts check ticks and classifies them in two pipeline stages.
module nfhf_front #(
	parameter int unsigned VarWidth = nfhf_pkg::VARIANCE_WIDTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nfhf_pkg::nfhf_cfg_t cfg,
	nfhf_in_if.sink             tick,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output nfhf_pkg::nfhf_cmd_t cmd
);
	import nfhf_pkg::*;

	// Compare width covers both the variances and the threshold.
	localparam int unsigned CmpWidth = (VarWidth > THRESHOLD_WIDTH) ? VarWidth : THRESHOLD_WIDTH;
	localparam int unsigned SqWidth  = 2 * CmpWidth;
	localparam int unsigned SumWidth = SqWidth + 2;

	logic [CmpWidth-1:0] thr, vel, pos, mx, my, mz;
	logic [CmpWidth:0]   thr2;
	logic                s1_free, s2_free;

	logic                v_s1;
	logic [SqWidth-1:0]  sq_x_s1, sq_y_s1, sq_z_s1, sq_t_s1;
	logic                ignore_s1, clear_s1, mag_big_s1, vel_ge_s1, pos_ge_s1;
	logic                vel_ge2_s1, flow_s1, pos_ok_s1, req_pos_s1;
	logic [31:0]         now_s1;

	logic                v_s2;
	nfhf_cmd_t           cmd_s2;

	logic [SumWidth-1:0] sq_sum;
	logic                mag_over;
	logic [2:0]          score;
	logic                bad_tick;
	cmd_kind_t           kind;

	assign thr  = CmpWidth'(cfg.ekf_threshold);
	assign thr2 = {thr, 1'b0};
	assign vel  = CmpWidth'(tick.vel_variance);
	assign pos  = CmpWidth'(tick.pos_variance);
	assign mx   = CmpWidth'(tick.mag_variance_x);
	assign my   = CmpWidth'(tick.mag_variance_y);
	assign mz   = CmpWidth'(tick.mag_variance_z);

	assign s2_free    = !v_s2 || cmd_ready;
	assign s1_free    = !v_s1 || s2_free;
	assign tick.ready = s1_free;

	// Stage 1: squares and the threshold compares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && tick.valid) begin
			sq_x_s1    <= SqWidth'(mx) * SqWidth'(mx);
			sq_y_s1    <= SqWidth'(my) * SqWidth'(my);
			sq_z_s1    <= SqWidth'(mz) * SqWidth'(mz);
			sq_t_s1    <= SqWidth'(thr) * SqWidth'(thr);
			ignore_s1  <= !tick.origin_valid;
			clear_s1   <= !tick.armed || (thr == '0);
			mag_big_s1 <= (mx >= thr) || (my >= thr) || (mz >= thr);
			vel_ge_s1  <= vel >= thr;
			pos_ge_s1  <= pos >= thr;
			vel_ge2_s1 <= {1'b0, vel} >= thr2;
			flow_s1    <= tick.flow_healthy;
			pos_ok_s1  <= tick.inertial_nav_ok && (tick.nav_flags[0] || tick.nav_flags[2])
			              && !tick.nav_flags[4];
			req_pos_s1 <= tick.needs_position;
			now_s1     <= tick.now_ms;
		end
	end

	// Stage 2: magnetometer length by squares, scoring, classification.
	always_comb begin
		sq_sum   = SumWidth'(sq_x_s1) + SumWidth'(sq_y_s1) + SumWidth'(sq_z_s1);
		mag_over = mag_big_s1 || (sq_sum >= SumWidth'(sq_t_s1));
		score    = 3'(mag_over) + 3'(vel_ge_s1) + 3'(pos_ge_s1);
		if (!flow_s1 && vel_ge2_s1) begin
			score = score + 3'd2;
		end else if (vel_ge_s1) begin
			score = score + 3'd1;
		end
		bad_tick = (score >= 3'd2) || !pos_ok_s1;
		priority if (ignore_s1) begin
			kind = CMD_IGNORE;
		end else if (clear_s1) begin
			kind = CMD_CLEAR;
		end else if (bad_tick) begin
			kind = CMD_BAD;
		end else begin
			kind = CMD_GOOD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && v_s1) begin
			cmd_s2.kind           <= kind;
			cmd_s2.needs_position <= req_pos_s1;
			cmd_s2.now_ms         <= now_s1;
		end
	end

	assign cmd_valid = v_s2;
	assign cmd       = cmd_s2;

endmodule

[sv/nfhf_queue.sv]
// Short command queue between the front end and the back end.
module nfhf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  nfhf_pkg::nfhf_cmd_t push_cmd,
	output logic                pop_valid,
	input  logic                pop_ready,
	output nfhf_pkg::nfhf_cmd_t pop_cmd
);
	import nfhf_pkg::*;

	localparam int unsigned PtrWidth = $clog2(QUEUE_DEPTH);

	nfhf_cmd_t             slots_q [QUEUE_DEPTH];
	logic [PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PtrWidth:0]     count_q;
	logic                  do_push, do_pop;

	assign push_ready = count_q != (PtrWidth+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[sv/nfhf_back.sv]
// Back end: counter, flags, warning timer and failsafe latch, with the result register.
module nfhf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  nfhf_pkg::nfhf_cfg_t cfg,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  nfhf_pkg::nfhf_cmd_t cmd,
	nfhf_out_if.source          result
);
	import nfhf_pkg::*;

	logic [7:0]  count_q, count_d, count_inc, count_dec;
	logic        bad_q, bad_d;
	logic [31:0] last_warn_q, last_warn_d;
	logic        latched_q, latched_d;
	logic        out_valid_q;
	logic        do_step;

	var_event_t  vev;
	fs_event_t   fev;
	fs_msg_t     msg;
	logic        warn, hold;

	logic        res_bad_q, res_active_q, res_warn_q, res_hold_q;
	var_event_t  res_vev_q;
	fs_event_t   res_fev_q;
	fs_msg_t     res_msg_q;

	assign cmd_ready = !out_valid_q || result.ready;
	assign do_step   = cmd_valid && cmd_ready;
	assign count_inc = count_q + 8'd1;
	assign count_dec = count_q - 8'd1;

	always_comb begin
		count_d     = count_q;
		bad_d       = bad_q;
		last_warn_d = last_warn_q;
		latched_d   = latched_q;
		vev         = VEV_NONE;
		fev         = FEV_NONE;
		msg         = MSG_NONE;
		warn        = 1'b0;
		hold        = 1'b0;
		unique case (cmd.kind)
			CMD_IGNORE: begin
			end
			CMD_CLEAR: begin
				count_d = '0;
				bad_d   = 1'b0;
				if (latched_q) begin
					latched_d = 1'b0;
					fev       = FEV_RESOLVED;
					msg       = MSG_CLEARED;
				end
			end
			CMD_BAD: begin
				if (!bad_q) begin
					count_d = count_inc;
					if (count_inc >= cfg.fail_limit) begin
						count_d = cfg.fail_limit;
						bad_d   = 1'b1;
						vev     = VEV_BAD;
						if ((cmd.now_ms - last_warn_q) > cfg.warn_interval_ms) begin
							warn        = 1'b1;
							last_warn_d = cmd.now_ms;
						end
						if (!latched_q) begin
							latched_d = 1'b1;
							fev       = FEV_ENGAGED;
							if (cmd.needs_position && cfg.failsafe_action != ACT_DISABLE) begin
								msg  = MSG_FAILSAFE;
								hold = cfg.failsafe_action >= ACT_HOLD;
							end
						end
					end
				end
			end
			CMD_GOOD: begin
				if (count_q != '0) begin
					count_d = count_dec;
					if (bad_q && count_dec == '0) begin
						bad_d = 1'b0;
						vev   = VEV_CLEARED;
						if (latched_q) begin
							latched_d = 1'b0;
							fev       = FEV_RESOLVED;
							msg       = MSG_CLEARED;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			bad_q       <= 1'b0;
			last_warn_q <= '0;
			latched_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_step) begin
				count_q     <= count_d;
				bad_q       <= bad_d;
				last_warn_q <= last_warn_d;
				latched_q   <= latched_d;
			end
			if (cmd_ready) begin
				out_valid_q <= cmd_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			res_bad_q    <= bad_d;
			res_active_q <= latched_d;
			res_vev_q    <= vev;
			res_fev_q    <= fev;
			res_warn_q   <= warn;
			res_msg_q    <= msg;
			res_hold_q   <= hold;
		end
	end

	assign result.valid                 = out_valid_q;
	assign result.variance_bad          = res_bad_q;
	assign result.failsafe_active       = res_active_q;
	assign result.variance_event        = res_vev_q;
	assign result.failsafe_event        = res_fev_q;
	assign result.send_variance_warning = res_warn_q;
	assign result.failsafe_message      = res_msg_q;
	assign result.request_hold          = res_hold_q;

endmodule

[sv/nav_filter_health_failsafe.sv]
// Top level of the navigation filter health check with latched failsafe.
// Each tick transaction carries the filter variances, the magnetometer variance vector,
// health flags and the time, and yields exactly one result transaction with the
// bad-variance flag, the failsafe state, the event codes, the warning strobe, the
// message code and the hold request. The block takes one tick transaction per clock
// cycle in steady state, while results are taken. The edge that accepts the tick registers
// the squares and threshold compares; the scored and classified command is then
// registered, it then enters the command queue, and the back-end state update then loads
// the result register from the queue head; back-pressure can stall each step. The
// sustained rate is set by the state update in the back end; the queue lets the front end
// keep accepting while a result waits to be taken. Configuration registers are written
// through cfg_we, cfg_index and cfg_data and take effect for ticks accepted afterward;
// they should be written only while no tick is in flight. Reset restores the threshold
// to 205, the action to hold, the fail limit to ten and the warning interval to thirty
// seconds.
module nav_filter_health_failsafe #(
	parameter int unsigned VARIANCE_WIDTH = nfhf_pkg::VARIANCE_WIDTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [nfhf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [nfhf_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	nfhf_in_if.sink                              tick,
	nfhf_out_if.source                           result
);
	import nfhf_pkg::*;

	// Configuration registers, loaded by the plain write port.
	nfhf_cfg_t cfg_q;

	// Handshake between the front end and the queue, and between the queue and the back end.
	logic      front_valid, front_ready;
	nfhf_cmd_t front_cmd;
	logic      back_valid, back_ready;
	nfhf_cmd_t back_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ekf_threshold    <= THRESHOLD_RESET;
			cfg_q.failsafe_action  <= ACTION_RESET;
			cfg_q.fail_limit       <= FAIL_LIMIT_RESET;
			cfg_q.warn_interval_ms <= WARN_INTERVAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EKF_THRESHOLD:   cfg_q.ekf_threshold    <= cfg_data[THRESHOLD_WIDTH-1:0];
				REG_FAILSAFE_ACTION: cfg_q.failsafe_action  <= cfg_data[1:0];
				REG_FAIL_LIMIT:      cfg_q.fail_limit       <= cfg_data[7:0];
				REG_WARN_INTERVAL:   cfg_q.warn_interval_ms <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	// The front end scores every tick and reduces it to one command for the back end.
	nfhf_front #(
		.VarWidth (VARIANCE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.tick      (tick),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	// The queue decouples front-end stalls from result back-pressure.
	nfhf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd)
	);

	// The back end holds all persistent state and drives the result register.
	nfhf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.result    (result)
	);

	// An engaged failsafe is reported only together with an active latch.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.failsafe_event == FEV_ENGAGED |-> result.failsafe_active)
		else $error("failsafe engaged without an active latch");

	// Variance declared bad must show the bad flag in the same result.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.variance_event == VEV_BAD |-> result.variance_bad)
		else $error("variance became bad but the flag is clear");

	// A hold request only comes with a fresh engagement and its failsafe message.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.request_hold
		|-> result.failsafe_event == FEV_ENGAGED && result.failsafe_message == MSG_FAILSAFE)
		else $error("hold requested outside a failsafe engagement");

	// The cleared message belongs to a resolution, after which the latch is released.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.failsafe_message == MSG_CLEARED
		|-> result.failsafe_event == FEV_RESOLVED && !result.failsafe_active)
		else $error("cleared message without a failsafe resolution");

endmodule
